FILE: rtl/lrr_pkg.sv
// Shared constants and types of the longest-run-with-replacements block.
`default_nettype none

package lrr_pkg;

  // String store depth and alphabet size.
  localparam int MAX_STRING = 16384;
  localparam int ALPHABET   = 26;

  // Field widths.
  localparam int LETTER_W = 5;
  localparam int LEN_W    = 15;
  localparam int ADDR_W   = $clog2(MAX_STRING);

  // One step handed from the input register to the window logic.
  typedef struct packed {
    logic                fire;
    logic [LETTER_W-1:0] letter;
    logic                first;
  } step_t;

  // Write port of the symbol store.
  typedef struct packed {
    logic                en;
    logic [ADDR_W-1:0]   addr;
    logic [LETTER_W-1:0] data;
  } store_wr_t;

  // One result item.
  typedef struct packed {
    logic [LEN_W-1:0] best_length;
    logic             overflow;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/lrr_if.sv
// Channel interfaces for the symbol input, the result output and the configuration write.
`default_nettype none

interface lrr_in_if;
  logic                         valid;
  logic                         ready;
  logic [lrr_pkg::LETTER_W-1:0] letter;
  logic                         first_of_string;

  modport source (output valid, letter, first_of_string, input ready);
  modport sink   (input valid, letter, first_of_string, output ready);
endinterface

interface lrr_out_if;
  logic                      valid;
  logic                      ready;
  logic [lrr_pkg::LEN_W-1:0] best_length;
  logic                      overflow;

  modport source (output valid, best_length, overflow, input ready);
  modport sink   (input valid, best_length, overflow, output ready);
endinterface

interface lrr_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [lrr_pkg::LEN_W-1:0] max_replacements;

  modport source (output valid, max_replacements, input ready);
  modport sink   (input valid, max_replacements, output ready);
endinterface

`default_nettype wire

FILE: rtl/lrr_store.sv
// Symbol store with a registered read port and write-to-read forwarding.
`default_nettype none

module lrr_store (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire  lrr_pkg::store_wr_t     wr_i,
  input  wire  [lrr_pkg::ADDR_W-1:0]   rd_addr_i,
  output logic [lrr_pkg::LETTER_W-1:0] head_o
);
  import lrr_pkg::*;

  logic [LETTER_W-1:0] mem [MAX_STRING];
  logic [LETTER_W-1:0] rd_data_q;
  logic [LETTER_W-1:0] fwd_data_q;
  logic                fwd_valid_q;
  logic                fwd_valid_d;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rd_data_q  <= mem[rd_addr_i];
    fwd_data_q <= wr_i.data;
  end

  // A write to the address being read must win over the stale read data.
  assign fwd_valid_d = wr_i.en && (wr_i.addr == rd_addr_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
    end else begin
      fwd_valid_q <= fwd_valid_d;
    end
  end

  assign head_o = fwd_valid_q ? fwd_data_q : rd_data_q;

endmodule

`default_nettype wire

FILE: rtl/lrr_window.sv
// Sliding window state: per-letter counts, highest count, window bounds and overflow flag.
`default_nettype none

module lrr_window (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire  lrr_pkg::step_t         step_i,
  input  wire  [lrr_pkg::LEN_W-1:0]    max_repl_i,
  input  wire  [lrr_pkg::LETTER_W-1:0] head_i,
  output lrr_pkg::store_wr_t           wr_o,
  output logic [lrr_pkg::ADDR_W-1:0]   rd_addr_o,
  output lrr_pkg::result_t             res_o
);
  import lrr_pkg::*;

  logic [LEN_W-1:0] cnt_q [ALPHABET];
  logic [LEN_W-1:0] cnt_d [ALPHABET];
  logic [LEN_W-1:0] high_q, high_d;
  logic [LEN_W-1:0] start_q, start_d;
  logic [LEN_W-1:0] end_q, end_d;
  logic             ovf_q, ovf_d;

  logic [LEN_W-1:0] cnt_inc [ALPHABET];
  logic [LEN_W-1:0] high_eff, start_eff, end_eff, sel_inc;
  logic             clr, ovf_eff, sym_ok, take, drop;
  logic [LEN_W:0]   win_len, limit;

  always_comb begin
    clr       = step_i.fire && step_i.first;
    high_eff  = clr ? '0 : high_q;
    start_eff = clr ? '0 : start_q;
    end_eff   = clr ? '0 : end_q;
    ovf_eff   = clr ? 1'b0 : ovf_q;

    sym_ok = step_i.letter < LETTER_W'(ALPHABET);
    take   = step_i.fire && sym_ok && (end_eff < LEN_W'(MAX_STRING));

    // Count the incoming letter and pick its new count.
    sel_inc = '0;
    for (int i = 0; i < ALPHABET; i++) begin
      cnt_inc[i] = clr ? '0 : cnt_q[i];
      if (take && (step_i.letter == LETTER_W'(i))) begin
        cnt_inc[i] = cnt_inc[i] + LEN_W'(1);
        sel_inc    = cnt_inc[i];
      end
    end

    end_d  = end_eff + LEN_W'(take);
    high_d = (take && (sel_inc > high_eff)) ? sel_inc : high_eff;

    // Shrink from the left when the window needs too many replacements.
    win_len = {1'b0, end_d - start_eff};
    limit   = {1'b0, high_d} + {1'b0, max_repl_i};
    drop    = take && (win_len > limit);
    start_d = start_eff + LEN_W'(drop);

    for (int i = 0; i < ALPHABET; i++) begin
      cnt_d[i] = cnt_inc[i];
      if (drop && (head_i == LETTER_W'(i)) && (cnt_inc[i] != '0)) begin
        cnt_d[i] = cnt_inc[i] - LEN_W'(1);
      end
    end

    ovf_d = ovf_eff || (step_i.fire && sym_ok && !take);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ALPHABET; i++) begin
        cnt_q[i] <= '0;
      end
      high_q  <= '0;
      start_q <= '0;
      end_q   <= '0;
      ovf_q   <= 1'b0;
    end else if (step_i.fire) begin
      for (int i = 0; i < ALPHABET; i++) begin
        cnt_q[i] <= cnt_d[i];
      end
      high_q  <= high_d;
      start_q <= start_d;
      end_q   <= end_d;
      ovf_q   <= ovf_d;
    end
  end

  assign wr_o.en   = take;
  assign wr_o.addr = end_eff[ADDR_W-1:0];
  assign wr_o.data = step_i.letter;

  // The store keeps the oldest window symbol ready for the next step.
  assign rd_addr_o = step_i.fire ? start_d[ADDR_W-1:0] : start_q[ADDR_W-1:0];

  assign res_o.best_length = end_d - start_d;
  assign res_o.overflow    = ovf_d;

endmodule

`default_nettype wire

FILE: rtl/longest_run_with_replacements.sv
// Top level of the streaming longest-run-with-replacements block.
`default_nettype none

// This block takes a string one letter (0 for A up to 25 for Z) per transaction
// and returns one result transaction for each, giving the length of the longest
// substring so far that can be turned into a single repeated letter by replacing
// at most max_replacements symbols, plus a sticky overflow flag. Setting
// first_of_string on a letter starts a new string. A new letter is accepted in
// every clock cycle while the output side is not stalled; each letter passes
// through the input register into the output register, where its result waits
// until the receiver takes it. The rate is set by the window update, which
// reads the oldest symbol from a registered store port that is kept pointed at
// the window start. Letters of 26 and above are ignored but still return the
// current answer, and strings longer than 16384 symbols raise overflow and
// hold their last length. The configuration register may be written only while
// no transaction is in flight.
module longest_run_with_replacements (
  input  wire clk_i,
  input  wire rst_ni,
  lrr_in_if.sink    in_i,
  lrr_cfg_if.sink   cfg_i,
  lrr_out_if.source out_o
);
  import lrr_pkg::*;

  // Input register.
  logic                in_valid_q, in_valid_d;
  logic [LETTER_W-1:0] in_letter_q;
  logic                in_first_q;

  // Output register.
  logic                out_valid_q, out_valid_d;
  result_t             out_q;

  // Configuration register.
  logic [LEN_W-1:0]    max_repl_q;

  logic                fire;
  logic                in_accept;
  step_t               step;
  store_wr_t           wr;
  logic [ADDR_W-1:0]   rd_addr;
  logic [LETTER_W-1:0] head;
  result_t             res_d;

  // The held item is processed whenever the output register is free or is
  // being emptied in this same cycle.
  assign fire      = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || fire;
  assign in_accept = in_i.valid && in_i.ready;

  assign in_valid_d  = in_accept || (in_valid_q && !fire);
  assign out_valid_d = fire || (out_valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      max_repl_q  <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid) begin
        max_repl_q <= cfg_i.max_replacements;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_letter_q <= in_i.letter;
      in_first_q  <= in_i.first_of_string;
    end
    if (fire) begin
      out_q <= res_d;
    end
  end

  assign cfg_i.ready = 1'b1;

  assign step.fire   = fire;
  assign step.letter = in_letter_q;
  assign step.first  = in_first_q;

  lrr_window u_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .max_repl_i (max_repl_q),
    .head_i     (head),
    .wr_o       (wr),
    .rd_addr_o  (rd_addr),
    .res_o      (res_d)
  );

  lrr_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (wr),
    .rd_addr_i (rd_addr),
    .head_o    (head)
  );

  assign out_o.valid       = out_valid_q;
  assign out_o.best_length = out_q.best_length;
  assign out_o.overflow    = out_q.overflow;

  // Every processed item must show up in the output register next cycle.
  a_fire_yields_result : assert property (
    @(posedge clk_i) disable iff (!rst_ni) fire |=> out_o.valid
  ) else $error("processed item did not reach the output register");

  // A held item must not vanish while the output side stalls.
  a_held_item_kept : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && !out_o.ready) |=> in_valid_q
  ) else $error("input register dropped an item during a stall");

  // Once the store is full no further symbol may be written into it.
  a_no_write_on_overflow : assert property (
    @(posedge clk_i) disable iff (!rst_ni) wr.en |-> !res_d.overflow
  ) else $error("symbol store written while overflow is reported");

endmodule

`default_nettype wire
